// ===== src/alf_pkg.sv =====
// ----------------------------------------------------------------------------
// alf_pkg: shared types and constants for the AC line frequency monitor
// Opcodes, register indexes, counter limits, config and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package alf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LENGTH  = 3'd0,
        REG_MIN_TOGGLES    = 3'd1,
        REG_MAX_TOGGLES    = 3'd2,
        REG_ERROR_LIMIT    = 3'd3,
        REG_EXPECTED_TICKS = 3'd4,
        REG_TICK_TOLERANCE = 3'd5
    } cfg_index_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_MONITOR = 1'b1
    } opcode_t;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  BAD_MAX   = 8'hFF;

    localparam logic [15:0] RST_WINDOW_LENGTH  = 16'd1000;
    localparam logic [15:0] RST_MIN_TOGGLES    = 16'd90;
    localparam logic [15:0] RST_MAX_TOGGLES    = 16'd130;
    localparam logic [7:0]  RST_ERROR_LIMIT    = 8'd12;
    localparam logic [15:0] RST_EXPECTED_TICKS = 16'd100;
    localparam logic [15:0] RST_TICK_TOLERANCE = 16'd5;

    typedef struct packed {
        logic [15:0] window_length;
        logic [15:0] min_toggles;
        logic [15:0] max_toggles;
        logic [7:0]  error_limit;
        logic [15:0] expected_ticks;
        logic [15:0] tick_tolerance;
    } alf_cfg_t;

    typedef struct packed {
        logic schedule_pulse;
        logic after_crossing;
        logic window_done;
        logic freq_fault_raise;
        logic freq_fault_clear;
        logic line_error;
        logic interrupt_fault;
        logic restart_monitor;
    } alf_result_t;

endpackage

`default_nettype wire

// ===== src/ac_line_frequency_monitor.sv =====
// ----------------------------------------------------------------------------
// ac_line_frequency_monitor: mains frequency monitor, zero-cross counting
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    opcode, line_level, ignore_check
//   out      source     out_valid/out_ready  8 status flags, one per request
//   cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// Result path: input register, then the update logic feeds the result
// register, which drives the result handshake. One request per cycle is
// sustained while the output is not stalled; the longest path is a 16-bit
// increment feeding a compare. A stalled output holds its result while one
// more request is taken into the input register. Reset is asynchronous and
// loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_line_frequency_monitor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [alf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [alf_pkg::CFG_DATA_W-1:0]   cfg_data,

    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             opcode,
    input  wire logic                             line_level,
    input  wire logic                             ignore_check,

    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  schedule_pulse,
    output logic                                  after_crossing,
    output logic                                  window_done,
    output logic                                  freq_fault_raise,
    output logic                                  freq_fault_clear,
    output logic                                  line_error,
    output logic                                  interrupt_fault,
    output logic                                  restart_monitor
);

    alf_pkg::alf_cfg_t    cfg;
    alf_pkg::alf_result_t core_result;

    // input stage
    logic s1_valid_reg, s1_valid_next;
    logic s1_opcode_reg;
    logic s1_level_reg;
    logic s1_ignore_reg;

    // result stage
    logic                 out_valid_reg, out_valid_next;
    alf_pkg::alf_result_t result_reg;

    logic in_take;
    logic out_free;
    logic s1_advance;

    alf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state commits only when the request moves into the result register
    alf_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .apply        (s1_advance),
        .opcode       (s1_opcode_reg),
        .line_level   (s1_level_reg),
        .ignore_check (s1_ignore_reg),
        .cfg          (cfg),
        .result       (core_result)
    );

    // handshake: input stage drains whenever the result slot is free
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;
    assign in_take    = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= opcode;
            s1_level_reg  <= line_level;
            s1_ignore_reg <= ignore_check;
        end
        if (s1_advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign schedule_pulse   = result_reg.schedule_pulse;
    assign after_crossing   = result_reg.after_crossing;
    assign window_done      = result_reg.window_done;
    assign freq_fault_raise = result_reg.freq_fault_raise;
    assign freq_fault_clear = result_reg.freq_fault_clear;
    assign line_error       = result_reg.line_error;
    assign interrupt_fault  = result_reg.interrupt_fault;
    assign restart_monitor  = result_reg.restart_monitor;

endmodule

`default_nettype wire

// ===== src/alf_cfg.sv =====
// ----------------------------------------------------------------------------
// alf_cfg: configuration register file
// Six write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [alf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [alf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output alf_pkg::alf_cfg_t                       cfg
);

    alf_pkg::alf_cfg_t cfg_reg;
    alf_pkg::alf_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (alf_pkg::cfg_index_t'(cfg_index))
                alf_pkg::REG_WINDOW_LENGTH:  cfg_next.window_length  = cfg_data;
                alf_pkg::REG_MIN_TOGGLES:    cfg_next.min_toggles    = cfg_data;
                alf_pkg::REG_MAX_TOGGLES:    cfg_next.max_toggles    = cfg_data;
                alf_pkg::REG_ERROR_LIMIT:    cfg_next.error_limit    = cfg_data[7:0];
                alf_pkg::REG_EXPECTED_TICKS: cfg_next.expected_ticks = cfg_data;
                alf_pkg::REG_TICK_TOLERANCE: cfg_next.tick_tolerance = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length  <= alf_pkg::RST_WINDOW_LENGTH;
            cfg_reg.min_toggles    <= alf_pkg::RST_MIN_TOGGLES;
            cfg_reg.max_toggles    <= alf_pkg::RST_MAX_TOGGLES;
            cfg_reg.error_limit    <= alf_pkg::RST_ERROR_LIMIT;
            cfg_reg.expected_ticks <= alf_pkg::RST_EXPECTED_TICKS;
            cfg_reg.tick_tolerance <= alf_pkg::RST_TICK_TOLERANCE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/alf_core.sv =====
// ----------------------------------------------------------------------------
// alf_core: monitor state and per-request update logic
// Holds crossing, window and tick state; computes one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          apply,
    input  wire logic          opcode,
    input  wire logic          line_level,
    input  wire logic          ignore_check,
    input  wire alf_pkg::alf_cfg_t cfg,
    output alf_pkg::alf_result_t result
);

    logic        prev_level_reg,       prev_level_next;
    logic        crossing_pending_reg, crossing_pending_next;
    logic [15:0] toggle_count_reg,     toggle_count_next;
    logic [15:0] window_timer_reg,     window_timer_next;
    logic [7:0]  bad_windows_reg,      bad_windows_next;
    logic        error_latched_reg,    error_latched_next;
    logic [15:0] tick_count_reg,       tick_count_next;

    logic        toggle;
    logic [15:0] toggles_now;
    logic [16:0] timer_inc;
    logic        done;
    logic        bad_window;
    logic [16:0] tick_plus_tol;
    logic [16:0] upper_bound;

    always_comb
    begin
        prev_level_next       = prev_level_reg;
        crossing_pending_next = crossing_pending_reg;
        toggle_count_next     = toggle_count_reg;
        window_timer_next     = window_timer_reg;
        bad_windows_next      = bad_windows_reg;
        error_latched_next    = error_latched_reg;
        tick_count_next       = tick_count_reg;
        result                = '0;

        // blanked tick after a crossing takes no sample
        toggle      = !crossing_pending_reg && (prev_level_reg != line_level);
        toggles_now = (toggle && toggle_count_reg != alf_pkg::COUNT_MAX)
                      ? toggle_count_reg + 16'd1 : toggle_count_reg;
        timer_inc   = {1'b0, window_timer_reg} + 17'd1;
        done        = timer_inc >= {1'b0, cfg.window_length};
        bad_window  = (toggles_now < cfg.min_toggles) || (toggles_now > cfg.max_toggles);

        // t < exp - tol rewritten as t + tol < exp: no negative bound
        tick_plus_tol = {1'b0, tick_count_reg} + {1'b0, cfg.tick_tolerance};
        upper_bound   = {1'b0, cfg.expected_ticks} + {1'b0, cfg.tick_tolerance};

        case (alf_pkg::opcode_t'(opcode))
            alf_pkg::OP_TICK:
            begin
                result.schedule_pulse = 1'b1;
                result.after_crossing = crossing_pending_reg;
                if (crossing_pending_reg)
                begin
                    crossing_pending_next = 1'b0;
                end
                else if (toggle)
                begin
                    prev_level_next       = line_level;
                    crossing_pending_next = 1'b1;
                end

                if (done)
                begin
                    result.window_done = 1'b1;
                    if (bad_window)
                    begin
                        if (bad_windows_reg != alf_pkg::BAD_MAX)
                        begin
                            bad_windows_next = bad_windows_reg + 8'd1;
                        end
                        if (bad_windows_next > cfg.error_limit)
                        begin
                            error_latched_next = 1'b1;
                        end
                    end
                    else
                    begin
                        result.freq_fault_clear = 1'b1;
                        error_latched_next      = 1'b0;
                    end
                    result.freq_fault_raise = error_latched_next;
                    window_timer_next       = '0;
                    toggle_count_next       = '0;
                end
                else
                begin
                    window_timer_next = timer_inc[15:0];
                    toggle_count_next = toggles_now;
                end

                if (tick_count_reg != alf_pkg::COUNT_MAX)
                begin
                    tick_count_next = tick_count_reg + 16'd1;
                end
            end
            alf_pkg::OP_MONITOR:
            begin
                if (ignore_check)
                begin
                    result.restart_monitor = 1'b1;
                end
                else
                begin
                    result.interrupt_fault =
                        (tick_plus_tol < {1'b0, cfg.expected_ticks}) ||
                        ({1'b0, tick_count_reg} > upper_bound);
                end
                tick_count_next = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.line_error = error_latched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg       <= 1'b0;
            crossing_pending_reg <= 1'b0;
            toggle_count_reg     <= '0;
            window_timer_reg     <= '0;
            bad_windows_reg      <= '0;
            error_latched_reg    <= 1'b0;
            tick_count_reg       <= '0;
        end
        else if (apply)
        begin
            prev_level_reg       <= prev_level_next;
            crossing_pending_reg <= crossing_pending_next;
            toggle_count_reg     <= toggle_count_next;
            window_timer_reg     <= window_timer_next;
            bad_windows_reg      <= bad_windows_next;
            error_latched_reg    <= error_latched_next;
            tick_count_reg       <= tick_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_ac_line_frequency_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_ac_line_frequency_monitor: self-checking bench for the line monitor
// Drives tick and monitor requests through the valid/ready request port,
// predicts the eight status flags of every request in a scoreboard class and
// compares them with each result taken from the output port. Register
// settings change between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------

class line_monitor_scoreboard;

    // register copy
    logic [15:0] window_length;
    logic [15:0] min_toggles;
    logic [15:0] max_toggles;
    logic [7:0]  error_limit;
    logic [15:0] expected_ticks;
    logic [15:0] tick_tolerance;

    // block state copy
    logic        prev_level;
    logic        crossing_pending;
    logic [15:0] toggle_count;
    logic [15:0] window_timer;
    logic [7:0]  bad_windows;
    logic        error_latched;
    logic [15:0] tick_count;

    alf_pkg::alf_result_t flags_due[$];

    int mismatches;
    int results_seen;
    int windows_closed;
    int fault_raises;
    int fault_clears;
    int tick_faults;
    int restarts;

    function new();
        window_length    = alf_pkg::RST_WINDOW_LENGTH;
        min_toggles      = alf_pkg::RST_MIN_TOGGLES;
        max_toggles      = alf_pkg::RST_MAX_TOGGLES;
        error_limit      = alf_pkg::RST_ERROR_LIMIT;
        expected_ticks   = alf_pkg::RST_EXPECTED_TICKS;
        tick_tolerance   = alf_pkg::RST_TICK_TOLERANCE;
        prev_level       = 1'b0;
        crossing_pending = 1'b0;
        toggle_count     = '0;
        window_timer     = '0;
        bad_windows      = '0;
        error_latched    = 1'b0;
        tick_count       = '0;
        mismatches       = 0;
        results_seen     = 0;
        windows_closed   = 0;
        fault_raises     = 0;
        fault_clears     = 0;
        tick_faults      = 0;
        restarts         = 0;
    endfunction

    function void write_register(logic [alf_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [alf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            alf_pkg::REG_WINDOW_LENGTH:  window_length  = data;
            alf_pkg::REG_MIN_TOGGLES:    min_toggles    = data;
            alf_pkg::REG_MAX_TOGGLES:    max_toggles    = data;
            alf_pkg::REG_ERROR_LIMIT:    error_limit    = data[7:0];
            alf_pkg::REG_EXPECTED_TICKS: expected_ticks = data;
            alf_pkg::REG_TICK_TOLERANCE: tick_tolerance = data;
            default:                     ;
        endcase
    endfunction

    // Work out the flags of one accepted request and queue them.
    function void note_request(alf_pkg::opcode_t op, logic lvl, logic ign);
        alf_pkg::alf_result_t flags;
        logic [16:0] next_timer;
        int          lower;
        int          upper;
        int          ticks;
        flags = '0;
        if (op == alf_pkg::OP_TICK)
        begin
            flags.schedule_pulse = 1'b1;
            if (crossing_pending)
            begin
                crossing_pending     = 1'b0;
                flags.after_crossing = 1'b1;
            end
            else if (prev_level != lvl)
            begin
                prev_level       = lvl;
                crossing_pending = 1'b1;
                if (toggle_count != alf_pkg::COUNT_MAX)
                    toggle_count = toggle_count + 16'd1;
            end
            next_timer = {1'b0, window_timer} + 17'd1;
            if (next_timer >= {1'b0, window_length})
            begin
                flags.window_done = 1'b1;
                if (toggle_count < min_toggles || toggle_count > max_toggles)
                begin
                    if (bad_windows != alf_pkg::BAD_MAX)
                        bad_windows = bad_windows + 8'd1;
                    if (bad_windows > error_limit)
                        error_latched = 1'b1;
                end
                else
                begin
                    flags.freq_fault_clear = 1'b1;
                    error_latched          = 1'b0;
                end
                flags.freq_fault_raise = error_latched;
                window_timer           = '0;
                toggle_count           = '0;
            end
            else
                window_timer = next_timer[15:0];
            if (tick_count != alf_pkg::COUNT_MAX)
                tick_count = tick_count + 16'd1;
        end
        else
        begin
            if (ign)
                flags.restart_monitor = 1'b1;
            else
            begin
                // bounds in plain int, so a tolerance above the target stays negative
                lower = expected_ticks;
                lower = lower - tick_tolerance;
                upper = expected_ticks;
                upper = upper + tick_tolerance;
                ticks = tick_count;
                if (ticks < lower || ticks > upper)
                    flags.interrupt_fault = 1'b1;
            end
            tick_count = '0;
        end
        flags.line_error = error_latched;
        flags_due.push_back(flags);
    endfunction

    function void compare_flag(string field, logic want, logic seen);
        if (want !== seen)
        begin
            mismatches++;
            $display("%0t: %s expected %0b actual %0b", $time, field, want, seen);
        end
    endfunction

    function void check_result(alf_pkg::alf_result_t seen);
        alf_pkg::alf_result_t want;
        if (flags_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none actual %b", $time, seen);
            return;
        end
        want = flags_due.pop_front();
        results_seen++;
        windows_closed += want.window_done;
        fault_raises   += want.freq_fault_raise;
        fault_clears   += want.freq_fault_clear;
        tick_faults    += want.interrupt_fault;
        restarts       += want.restart_monitor;
        compare_flag("schedule_pulse",   want.schedule_pulse,   seen.schedule_pulse);
        compare_flag("after_crossing",   want.after_crossing,   seen.after_crossing);
        compare_flag("window_done",      want.window_done,      seen.window_done);
        compare_flag("freq_fault_raise", want.freq_fault_raise, seen.freq_fault_raise);
        compare_flag("freq_fault_clear", want.freq_fault_clear, seen.freq_fault_clear);
        compare_flag("line_error",       want.line_error,       seen.line_error);
        compare_flag("interrupt_fault",  want.interrupt_fault,  seen.interrupt_fault);
        compare_flag("restart_monitor",  want.restart_monitor,  seen.restart_monitor);
    endfunction

    function int pending();
        return flags_due.size();
    endfunction

endclass

module tb_ac_line_frequency_monitor;

    // register indexes past the last real register; writes there must do nothing
    localparam logic [alf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [alf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 105;
    localparam int LONG_HOLD   = 40;     // cycles the sink refuses results once
    localparam int SETTLE      = 4;      // cycles past the last result

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [alf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [alf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic line_level;
    logic ignore_check;
    logic out_valid;
    logic out_ready;
    logic schedule_pulse;
    logic after_crossing;
    logic window_done;
    logic freq_fault_raise;
    logic freq_fault_clear;
    logic line_error;
    logic interrupt_fault;
    logic restart_monitor;

    // idle control, shared between the request side and the result side
    bit sender_idle;
    bit receiver_idle;
    bit long_hold_req;
    int hold_left;

    line_monitor_scoreboard line_sb = new();

    ac_line_frequency_monitor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .line_level       (line_level),
        .ignore_check     (ignore_check),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .schedule_pulse   (schedule_pulse),
        .after_crossing   (after_crossing),
        .window_done      (window_done),
        .freq_fault_raise (freq_fault_raise),
        .freq_fault_clear (freq_fault_clear),
        .line_error       (line_error),
        .interrupt_fault  (interrupt_fault),
        .restart_monitor  (restart_monitor)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #12_000_000;
        $display("timeout: %0d results still due", line_sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side. Values are taken as they stood just before the edge, so a
    // result counts exactly when out_valid and out_ready were both high there.
    // out_ready drops for random bursts, or for one long hold when asked.
    initial
    begin : result_sink
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                line_sb.check_result({schedule_pulse, after_crossing, window_done,
                                      freq_fault_raise, freq_fault_clear, line_error,
                                      interrupt_fault, restart_monitor});
            if (hold_left > 0)
                hold_left--;
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (receiver_idle && $urandom_range(0, 3) == 0)
                hold_left = $urandom_range(1, 5);
            out_ready <= (hold_left == 0) && rst_n;
        end
    end

    // Offer one request and return at the edge that takes it. An optional
    // idle burst comes first; valid stays high from one request to the next.
    task automatic send_request(input alf_pkg::opcode_t op, input logic lvl,
                                input logic ign);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        line_level   <= lvl;
        ignore_check <= ign;
        do
            @(posedge clk);
        while (!in_ready);
        line_sb.note_request(op, lvl, ign);
    endtask

    // Stop offering and let every due result come back, plus pipe latency.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (line_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write per edge; the enable stays high across a burst.
    task automatic put_register(input logic [alf_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [alf_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        line_sb.write_register(idx, data);
    endtask

    // Drain, then load all six registers and poke one spare index.
    // The error limit goes out with junk in its upper byte, which must be dropped.
    task automatic apply_settings(input alf_pkg::alf_cfg_t s);
        logic [alf_pkg::CFG_INDEX_W-1:0] spare;
        wait_idle();
        spare = ($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        put_register(alf_pkg::REG_WINDOW_LENGTH,  s.window_length);
        put_register(alf_pkg::REG_MIN_TOGGLES,    s.min_toggles);
        put_register(alf_pkg::REG_MAX_TOGGLES,    s.max_toggles);
        put_register(alf_pkg::REG_ERROR_LIMIT,    {8'($urandom), s.error_limit});
        put_register(alf_pkg::REG_EXPECTED_TICKS, s.expected_ticks);
        put_register(alf_pkg::REG_TICK_TOLERANCE, s.tick_tolerance);
        put_register(spare, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        alf_pkg::alf_cfg_t s;
        int       wl;
        int       half_period;
        int       run_left;
        logic     lvl;

        in_valid      <= 1'b0;
        opcode        <= alf_pkg::OP_TICK;
        line_level    <= 1'b0;
        ignore_check  <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= alf_pkg::REG_WINDOW_LENGTH;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        long_hold_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings (1000-tick window, 100 +/- 5) ----
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);   // zero ticks, under the lower bound
        send_request(alf_pkg::OP_MONITOR, 1'b1, 1'b1);   // skipped check, level bit unused
        send_request(alf_pkg::OP_TICK,    1'b1, 1'b0);   // rising edge: one toggle
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b1);   // blanked tick after a crossing
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b1, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b1, 1'b0);

        // Window shrunk under the running timer: next tick closes it.
        // Tolerance above the target makes the lower bound negative.
        s = '{window_length: 16'd3, min_toggles: 16'd0, max_toggles: 16'd0,
              error_limit: 8'd0, expected_ticks: 16'd2, tick_tolerance: 16'd5};
        apply_settings(s);
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);   // blanked tick + bad window, latch
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);   // window closes with one toggle: bad, latch holds
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);   // too many ticks
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);   // zero ticks, can't go under

        // Zero window length with every other register at its top value.
        s = '{window_length: 16'd0, min_toggles: 16'hFFFF, max_toggles: 16'hFFFF,
              error_limit: 8'hFF, expected_ticks: 16'hFFFF, tick_tolerance: 16'hFFFF};
        apply_settings(s);
        send_request(alf_pkg::OP_TICK,    1'b1, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b1, 1'b0);
        send_request(alf_pkg::OP_TICK,    1'b0, 1'b0);
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);

        // One-tick windows, exactly one toggle wanted.
        s = '{window_length: 16'd1, min_toggles: 16'd1, max_toggles: 16'd1,
              error_limit: 8'd2, expected_ticks: 16'd0, tick_tolerance: 16'd0};
        apply_settings(s);
        for (int k = 0; k < 6; k++)
            send_request(alf_pkg::OP_TICK, k[0], 1'b0);
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);

        // ---- random phases ----
        // A square wave with a random half period, a few glitches mixed in,
        // and monitor events at random spacing.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0)
                s = '0;
            else if (phase == 1)
                s = '{window_length: 16'hFFFF, min_toggles: 16'hFFFF,
                      max_toggles: 16'hFFFF, error_limit: 8'hFF,
                      expected_ticks: 16'hFFFF, tick_tolerance: 16'hFFFF};
            else
            begin
                wl = (phase == 5) ? $urandom_range(40, 200) : $urandom_range(0, 12);
                s.window_length  = 16'(wl);
                s.min_toggles    = 16'($urandom_range(0, wl / 4 + 2));
                s.max_toggles    = s.min_toggles + 16'($urandom_range(0, wl / 4 + 2));
                if ($urandom_range(0, 5) == 0)
                    s.max_toggles = 16'($urandom_range(0, 2));   // often below min
                s.error_limit    = 8'($urandom_range(0, 24));
                s.expected_ticks = 16'($urandom_range(0, 12));
                s.tick_tolerance = 16'($urandom_range(0, 6));
            end
            apply_settings(s);

            // last phase runs flat out; others idle at random
            sender_idle   = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_idle = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            half_period   = $urandom_range(1, 4);
            lvl           = 1'($urandom);
            run_left      = half_period;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long sink stall while requests keep coming: pipe fills, in_ready drops
                if (phase == 3 && n == 20)
                    long_hold_req = 1'b1;
                // sender stops until every result is back
                if (phase == 4 && n == 70)
                    wait_idle();
                if ($urandom_range(0, 5) == 0)
                    send_request(alf_pkg::OP_MONITOR, 1'($urandom),
                                 $urandom_range(0, 2) == 0);
                else
                begin
                    if (run_left == 0)
                    begin
                        lvl      = ~lvl;
                        run_left = half_period;
                    end
                    run_left--;
                    if ($urandom_range(0, 7) == 0)
                        send_request(alf_pkg::OP_TICK, 1'($urandom), 1'($urandom));
                    else
                        send_request(alf_pkg::OP_TICK, lvl, 1'($urandom));
                end
            end
        end

        // ---- counter limits, no idling from here on ----
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;

        // min above max: every one-tick window is bad, bad count pins at its top
        s = '{window_length: 16'd0, min_toggles: 16'd1, max_toggles: 16'd0,
              error_limit: 8'hFF, expected_ticks: 16'd100, tick_tolerance: 16'd5};
        apply_settings(s);
        repeat (260)
            send_request(alf_pkg::OP_TICK, 1'($urandom), 1'b0);

        // limit one under the pinned count: a bad window latches again
        s = '{window_length: 16'd0, min_toggles: 16'd0, max_toggles: 16'd0,
              error_limit: 8'hFE, expected_ticks: 16'd100, tick_tolerance: 16'd5};
        apply_settings(s);
        repeat (8)
            send_request(alf_pkg::OP_TICK, 1'($urandom), 1'b0);

        // longest window, zero tolerance around a small target
        s = '{window_length: 16'hFFFF, min_toggles: 16'd0, max_toggles: 16'hFFFF,
              error_limit: 8'hFF, expected_ticks: 16'd3, tick_tolerance: 16'd0};
        apply_settings(s);
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b1);
        for (int k = 0; k < 6; k++)
            send_request(alf_pkg::OP_TICK, k[0], 1'b0);
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);   // over the target
        repeat (3)
            send_request(alf_pkg::OP_TICK, 1'b0, 1'b0);
        send_request(alf_pkg::OP_MONITOR, 1'b0, 1'b0);   // exactly on the target

        wait_idle();

        $display("checked %0d results: %0d windows closed, %0d fault raises, %0d clears",
                 line_sb.results_seen, line_sb.windows_closed,
                 line_sb.fault_raises, line_sb.fault_clears);
        $display("monitor events: %0d out of tolerance, %0d restarts; %0d flag mismatches",
                 line_sb.tick_faults, line_sb.restarts, line_sb.mismatches);
        if (line_sb.mismatches == 0 && line_sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
